[rtl/fhp_pkg.sv]
// ----------------------------------------------------------------------------
// fhp_pkg
// Shared types and constants for the framed response handshake parser.
// ----------------------------------------------------------------------------
package fhp_pkg;

  localparam int DEF_WINDOW_DEPTH = 64;
  localparam int DEF_MAX_PAYLOAD  = 55;

  // frame layout: sync[0..3] seq[4] type[5] len_lo[6] len_hi[7] payload checksum
  localparam int HDR_LEN     = 8;
  localparam int FRAME_EXTRA = 9;
  localparam int SYNC_LEN    = 4;
  localparam int POS_SEQ     = 4;
  localparam int POS_TYPE    = 5;
  localparam int POS_LEN_LO  = 6;
  localparam int POS_LEN_HI  = 7;

  localparam logic [1:0] MODE_BYTE     = 2'd0;
  localparam logic [1:0] MODE_START    = 2'd1;
  localparam logic [1:0] MODE_CFG_SENT = 2'd2;
  localparam logic [1:0] MODE_NONE     = 2'd3;

  localparam logic [1:0] REG_SYNC_WORD   = 2'd0;
  localparam logic [1:0] REG_FIRST_TYPE  = 2'd1;
  localparam logic [1:0] REG_SECOND_TYPE = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_AWAIT1   = 3'd1,
    PH_SEND_CFG = 3'd2,
    PH_AWAIT2   = 3'd3,
    PH_DONE     = 3'd4,
    PH_FAILED   = 3'd5
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_FRD,
    S_FCMP,
    S_TCHK,
    S_TRD,
    S_TCMP,
    S_HDR,
    S_H6,
    S_H7,
    S_LEN,
    S_SUM,
    S_DONE
  } scan_state_t;

  typedef struct packed {
    logic [2:0]  handshake_state;
    logic        response_accepted;
    logic [31:0] noise_count;
    logic [31:0] malformed_count;
    logic [31:0] unrelated_count;
    logic [31:0] accepted_count;
  } result_t;

endpackage

[rtl/framed_response_handshake_parser.sv]
// ----------------------------------------------------------------------------
// framed_response_handshake_parser
// Deframes handshake responses from a received byte stream.
// ----------------------------------------------------------------------------
// Requests on the input channel carry mode and rx_byte: a received byte, a
// start-handshake event or a configuration-sent event. Every request gives
// exactly one result on the output channel: the handshake state after the
// request, a response-accepted flag and the four wrapping statistics.
// Received bytes go into a circular byte window held in one synchronous RAM;
// while a response is awaited a sequencer scans the window through its single
// read port. Events, and bytes while no response is awaited, go from accept
// straight to the result state. A scanned byte runs the sync search byte by
// byte, the header reads and the checksum over the frame; every rejected frame
// slides one byte and restarts the search.
// One request is worked on at a time; the result sits in an output register,
// so the next request is taken while a stalled result waits. A further
// result waits in the sequencer until the output register frees up.
// Reset clears the phase, counters, window fill and config registers; no RAM clear.
// ----------------------------------------------------------------------------
module framed_response_handshake_parser #(
  parameter int WINDOW_DEPTH = fhp_pkg::DEF_WINDOW_DEPTH,
  parameter int MAX_PAYLOAD  = fhp_pkg::DEF_MAX_PAYLOAD
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  handshake_state,
  output logic        response_accepted,
  output logic [31:0] noise_count,
  output logic [31:0] malformed_count,
  output logic [31:0] unrelated_count,
  output logic [31:0] accepted_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [31:0]      sync_word;
  logic [7:0]       first_type;
  logic [7:0]       second_type;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [7:0]       mem_rdata;
  logic             res_ready;
  logic             res_valid;
  fhp_pkg::result_t res;
  fhp_pkg::result_t out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word   <= '0;
      first_type  <= '0;
      second_type <= '0;
    end else if (cfg_we) begin
      priority case (cfg_index)
        fhp_pkg::REG_SYNC_WORD:   sync_word   <= cfg_data;
        fhp_pkg::REG_FIRST_TYPE:  first_type  <= cfg_data[7:0];
        fhp_pkg::REG_SECOND_TYPE: second_type <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign handshake_state   = out_res.handshake_state;
  assign response_accepted = out_res.response_accepted;
  assign noise_count       = out_res.noise_count;
  assign malformed_count   = out_res.malformed_count;
  assign unrelated_count   = out_res.unrelated_count;
  assign accepted_count    = out_res.accepted_count;

  fhp_window_mem #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fhp_scan_ctrl #(
    .DEPTH       (WINDOW_DEPTH),
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .rx_byte     (rx_byte),
    .sync_word   (sync_word),
    .first_type  (first_type),
    .second_type (second_type),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res         (res)
  );

endmodule

[rtl/fhp_window_mem.sv]
// ----------------------------------------------------------------------------
// fhp_window_mem
// Byte window storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fhp_window_mem #(
  parameter int DEPTH = fhp_pkg::DEF_WINDOW_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fhp_scan_ctrl.sv]
// ----------------------------------------------------------------------------
// fhp_scan_ctrl
// Handshake phase, statistics and the sequencer that scans the byte window.
// ----------------------------------------------------------------------------
module fhp_scan_ctrl #(
  parameter int DEPTH       = fhp_pkg::DEF_WINDOW_DEPTH,
  parameter int MAX_PAYLOAD = fhp_pkg::DEF_MAX_PAYLOAD,
  parameter int AW          = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       mode,
  input  logic [7:0]       rx_byte,
  input  logic [31:0]      sync_word,
  input  logic [7:0]       first_type,
  input  logic [7:0]       second_type,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [7:0]       mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  logic [7:0]       mem_rdata,
  input  logic             res_ready,
  output logic             res_valid,
  output fhp_pkg::result_t res
);

  localparam int FW = $clog2(DEPTH + 1);
  localparam int SW = AW + 2;

  fhp_pkg::scan_state_t st, st_next;
  fhp_pkg::phase_t      phase, phase_next;
  logic [AW-1:0] head, head_next;
  logic [FW-1:0] fill, fill_next;
  logic [31:0]   noise, noise_next;
  logic [31:0]   malformed, malformed_next;
  logic [31:0]   unrelated, unrelated_next;
  logic [31:0]   accepted, accepted_next;
  logic [FW-1:0] pos, pos_next;
  logic [1:0]    k, k_next;
  logic [1:0]    keep, keep_next;
  logic [7:0]    kind, kind_next;
  logic [7:0]    len_lo, len_lo_next;
  logic [FW-1:0] total, total_next;
  logic [FW-1:0] idx, idx_next;
  logic [7:0]    sum, sum_next;
  logic          hit, hit_next;
  logic [FW-1:0] rd_off;
  logic [15:0]   len;
  logic [16:0]   tot;
  logic [7:0]    want;

  // window offset to physical address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [FW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [7:0] sync_byte(input logic [31:0] w, input logic [1:0] n);
    return w[{n, 3'b000} +: 8];
  endfunction

  assign mem_raddr = phys(head, rd_off);
  assign len       = {mem_rdata, len_lo};
  assign tot       = 17'(len) + 17'(fhp_pkg::FRAME_EXTRA);
  assign want      = (phase == fhp_pkg::PH_AWAIT1) ? first_type : second_type;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= fhp_pkg::S_IDLE;
      phase     <= fhp_pkg::PH_IDLE;
      fill      <= '0;
      head      <= '0;
      noise     <= '0;
      malformed <= '0;
      unrelated <= '0;
      accepted  <= '0;
      hit       <= 1'b0;
    end else begin
      st        <= st_next;
      phase     <= phase_next;
      fill      <= fill_next;
      head      <= head_next;
      noise     <= noise_next;
      malformed <= malformed_next;
      unrelated <= unrelated_next;
      accepted  <= accepted_next;
      hit       <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    pos    <= pos_next;
    k      <= k_next;
    keep   <= keep_next;
    kind   <= kind_next;
    len_lo <= len_lo_next;
    total  <= total_next;
    idx    <= idx_next;
    sum    <= sum_next;
  end

  always_comb begin
    st_next        = st;
    phase_next     = phase;
    head_next      = head;
    fill_next      = fill;
    noise_next     = noise;
    malformed_next = malformed;
    unrelated_next = unrelated;
    accepted_next  = accepted;
    hit_next       = hit;
    pos_next       = pos;
    k_next         = k;
    keep_next      = keep;
    kind_next      = kind;
    len_lo_next    = len_lo;
    total_next     = total;
    idx_next       = idx;
    sum_next       = sum;
    rd_off         = '0;
    mem_we         = 1'b0;
    mem_waddr      = phys(head, fill);
    mem_wdata      = rx_byte;
    in_stall       = 1'b1;
    res_valid      = 1'b0;

    unique case (st)
      fhp_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          hit_next = 1'b0;
          st_next  = fhp_pkg::S_DONE;
          priority case (mode)
            fhp_pkg::MODE_BYTE: begin
              mem_we = 1'b1;
              if (fill == FW'(DEPTH)) begin
                // full window: oldest byte goes out as noise
                noise_next = noise + 32'd1;
                mem_waddr  = head;
                head_next  = phys(head, FW'(1));
              end else begin
                fill_next = fill + FW'(1);
              end
              if (phase == fhp_pkg::PH_AWAIT1 || phase == fhp_pkg::PH_AWAIT2) begin
                st_next = fhp_pkg::S_SCAN;
              end
            end
            fhp_pkg::MODE_START: begin
              phase_next = (phase == fhp_pkg::PH_IDLE) ? fhp_pkg::PH_AWAIT1
                                                       : fhp_pkg::PH_FAILED;
            end
            fhp_pkg::MODE_CFG_SENT: begin
              if (phase == fhp_pkg::PH_SEND_CFG) begin
                fill_next  = '0;
                phase_next = fhp_pkg::PH_AWAIT2;
              end else begin
                phase_next = fhp_pkg::PH_FAILED;
              end
            end
            default: begin
            end
          endcase
        end
      end

      fhp_pkg::S_SCAN: begin
        if (fill == '0) begin
          st_next = fhp_pkg::S_DONE;
        end else if (fill < FW'(fhp_pkg::SYNC_LEN)) begin
          keep_next = fill[1:0];
          st_next   = fhp_pkg::S_TCHK;
        end else begin
          pos_next = '0;
          k_next   = '0;
          st_next  = fhp_pkg::S_FRD;
        end
      end

      fhp_pkg::S_FRD: begin
        rd_off  = pos + FW'(k);
        st_next = fhp_pkg::S_FCMP;
      end

      fhp_pkg::S_FCMP: begin
        if (mem_rdata == sync_byte(sync_word, k)) begin
          if (k == 2'd3) begin
            noise_next = noise + 32'(pos);
            head_next  = phys(head, pos);
            fill_next  = fill - pos;
            st_next    = fhp_pkg::S_HDR;
          end else begin
            k_next  = k + 2'd1;
            st_next = fhp_pkg::S_FRD;
          end
        end else if ((FW + 1)'(pos) + (FW + 1)'(fhp_pkg::SYNC_LEN + 1) <= (FW + 1)'(fill)) begin
          pos_next = pos + FW'(1);
          k_next   = '0;
          st_next  = fhp_pkg::S_FRD;
        end else begin
          keep_next = 2'd3;
          st_next   = fhp_pkg::S_TCHK;
        end
      end

      // keep the longest tail that could still start a sync word
      fhp_pkg::S_TCHK: begin
        if (keep == '0) begin
          noise_next = noise + 32'(fill);
          fill_next  = '0;
          st_next    = fhp_pkg::S_DONE;
        end else begin
          k_next  = '0;
          st_next = fhp_pkg::S_TRD;
        end
      end

      fhp_pkg::S_TRD: begin
        rd_off  = fill - FW'(keep) + FW'(k);
        st_next = fhp_pkg::S_TCMP;
      end

      fhp_pkg::S_TCMP: begin
        if (mem_rdata != sync_byte(sync_word, k)) begin
          keep_next = keep - 2'd1;
          st_next   = fhp_pkg::S_TCHK;
        end else if (k == keep - 2'd1) begin
          noise_next = noise + 32'(fill - FW'(keep));
          head_next  = phys(head, fill - FW'(keep));
          fill_next  = FW'(keep);
          st_next    = fhp_pkg::S_DONE;
        end else begin
          k_next  = k + 2'd1;
          st_next = fhp_pkg::S_TRD;
        end
      end

      fhp_pkg::S_HDR: begin
        rd_off = FW'(fhp_pkg::POS_TYPE);
        if (fill < FW'(fhp_pkg::HDR_LEN)) begin
          st_next = fhp_pkg::S_DONE;
        end else begin
          st_next = fhp_pkg::S_H6;
        end
      end

      fhp_pkg::S_H6: begin
        kind_next = mem_rdata;
        rd_off    = FW'(fhp_pkg::POS_LEN_LO);
        st_next   = fhp_pkg::S_H7;
      end

      fhp_pkg::S_H7: begin
        len_lo_next = mem_rdata;
        rd_off      = FW'(fhp_pkg::POS_LEN_HI);
        st_next     = fhp_pkg::S_LEN;
      end

      fhp_pkg::S_LEN: begin
        rd_off = FW'(fhp_pkg::POS_SEQ);
        if (len > 16'(MAX_PAYLOAD)) begin
          malformed_next = malformed + 32'd1;
          head_next      = phys(head, FW'(1));
          fill_next      = fill - FW'(1);
          st_next        = fhp_pkg::S_SCAN;
        end else if (17'(fill) < tot) begin
          st_next = fhp_pkg::S_DONE;
        end else begin
          total_next = tot[FW-1:0];
          sum_next   = '0;
          idx_next   = FW'(fhp_pkg::POS_SEQ);
          st_next    = fhp_pkg::S_SUM;
        end
      end

      // one byte per cycle; the byte at total-1 is the checksum
      fhp_pkg::S_SUM: begin
        rd_off = idx + FW'(1);
        if (idx == total - FW'(1)) begin
          if (sum != mem_rdata) begin
            malformed_next = malformed + 32'd1;
            head_next      = phys(head, FW'(1));
            fill_next      = fill - FW'(1);
            st_next        = fhp_pkg::S_SCAN;
          end else begin
            head_next = phys(head, total);
            fill_next = fill - total;
            if (kind != want) begin
              unrelated_next = unrelated + 32'd1;
              st_next        = fhp_pkg::S_SCAN;
            end else begin
              accepted_next = accepted + 32'd1;
              hit_next      = 1'b1;
              phase_next    = (phase == fhp_pkg::PH_AWAIT1) ? fhp_pkg::PH_SEND_CFG
                                                            : fhp_pkg::PH_DONE;
              st_next       = fhp_pkg::S_DONE;
            end
          end
        end else begin
          sum_next = sum ^ mem_rdata;
          idx_next = idx + FW'(1);
        end
      end

      fhp_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          st_next = fhp_pkg::S_IDLE;
        end
      end

      default: begin
        st_next = fhp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.handshake_state   = phase;
    res.response_accepted = hit;
    res.noise_count       = noise;
    res.malformed_count   = malformed;
    res.unrelated_count   = unrelated;
    res.accepted_count    = accepted;
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the framed response handshake parser.
// ----------------------------------------------------------------------------
// Drives one handshake through all phases. While a response is awaited it
// sends sync-word frames that are good, unrelated, corrupt, oversized or
// truncated, mixed with noise. The sync word and response types change
// between drained segments. A scoreboard predicts every result and compares
// the results field by field.
// ----------------------------------------------------------------------------
module testbench;

  class response_scoreboard;
    logic [7:0]         win [fhp_pkg::DEF_WINDOW_DEPTH];
    int                 fill;
    fhp_pkg::phase_t    phase;
    logic [31:0]        noise_total, malformed_total, unrelated_total, accepted_total;
    logic [31:0]        sync_word;
    logic [7:0]         first_type, second_type;
    fhp_pkg::result_t   expected_results[$];
    int                 errors;

    function void clear();
      fill = 0;
      phase = fhp_pkg::PH_IDLE;
      noise_total = 0;
      malformed_total = 0;
      unrelated_total = 0;
      accepted_total = 0;
      sync_word = 0;
      first_type = 0;
      second_type = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        fhp_pkg::REG_SYNC_WORD:   sync_word = data;
        fhp_pkg::REG_FIRST_TYPE:  first_type = data[7:0];
        fhp_pkg::REG_SECOND_TYPE: second_type = data[7:0];
        default: ;
      endcase
    endfunction

    function void drop_front(int count);
      if (count >= fill) begin
        fill = 0;
        return;
      end
      for (int i = 0; i < fill - count; i++) win[i] = win[i + count];
      fill -= count;
    endfunction

    function bit sync_at(int pos, int len);
      for (int k = 0; k < len; k++)
        if (win[pos + k] != sync_word[8*k +: 8]) return 0;
      return 1;
    endfunction

    function bit scan_window();
      int pos, keep, len, total;
      logic [7:0] sum, kind, want;
      if (phase != fhp_pkg::PH_AWAIT1 && phase != fhp_pkg::PH_AWAIT2) return 0;
      while (fill != 0) begin
        pos = fill;
        if (fill >= fhp_pkg::SYNC_LEN) begin
          for (int i = 0; i + fhp_pkg::SYNC_LEN <= fill; i++) begin
            if (sync_at(i, fhp_pkg::SYNC_LEN)) begin
              pos = i;
              break;
            end
          end
        end
        if (pos == fill) begin
          // keep a tail that could still grow into the sync word
          keep = fill < 3 ? fill : 3;
          while (keep != 0 && !sync_at(fill - keep, keep)) keep--;
          noise_total += fill - keep;
          drop_front(fill - keep);
          return 0;
        end
        if (pos != 0) begin
          noise_total += pos;
          drop_front(pos);
        end
        if (fill < fhp_pkg::HDR_LEN) return 0;
        len = {win[fhp_pkg::POS_LEN_HI], win[fhp_pkg::POS_LEN_LO]};
        if (len > fhp_pkg::DEF_MAX_PAYLOAD) begin
          malformed_total++;
          drop_front(1);
          continue;
        end
        total = fhp_pkg::FRAME_EXTRA + len;
        if (fill < total) return 0;
        sum = 0;
        for (int i = fhp_pkg::POS_SEQ; i + 1 < total; i++) sum ^= win[i];
        if (sum != win[total - 1]) begin
          malformed_total++;
          drop_front(1);
          continue;
        end
        kind = win[fhp_pkg::POS_TYPE];
        drop_front(total);
        want = (phase == fhp_pkg::PH_AWAIT1) ? first_type : second_type;
        if (kind != want) begin
          unrelated_total++;
          continue;
        end
        accepted_total++;
        phase = (phase == fhp_pkg::PH_AWAIT1) ? fhp_pkg::PH_SEND_CFG : fhp_pkg::PH_DONE;
        return 1;
      end
      return 0;
    endfunction

    function void note_request(logic [1:0] m, logic [7:0] b);
      fhp_pkg::result_t r;
      bit hit;
      hit = 0;
      case (m)
        fhp_pkg::MODE_BYTE: begin
          if (fill >= fhp_pkg::DEF_WINDOW_DEPTH) begin
            noise_total++;
            drop_front(1);
          end
          win[fill] = b;
          fill++;
          hit = scan_window();
          if (scan_window()) hit = 1;
        end
        fhp_pkg::MODE_START:
          phase = (phase == fhp_pkg::PH_IDLE) ? fhp_pkg::PH_AWAIT1 : fhp_pkg::PH_FAILED;
        fhp_pkg::MODE_CFG_SENT: begin
          if (phase == fhp_pkg::PH_SEND_CFG) begin
            fill = 0;
            phase = fhp_pkg::PH_AWAIT2;
          end else begin
            phase = fhp_pkg::PH_FAILED;
          end
        end
        default: ;
      endcase
      r.handshake_state = phase;
      r.response_accepted = hit;
      r.noise_count = noise_total;
      r.malformed_count = malformed_total;
      r.unrelated_count = unrelated_total;
      r.accepted_count = accepted_total;
      expected_results = {expected_results, r};
    endfunction

    function void check_result(fhp_pkg::result_t act);
      fhp_pkg::result_t exp;
      if (expected_results.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      exp = expected_results.pop_front();
      if (act.handshake_state !== exp.handshake_state) begin
        $error("handshake_state exp %0d got %0d", exp.handshake_state, act.handshake_state);
        errors++;
      end
      if (act.response_accepted !== exp.response_accepted) begin
        $error("response_accepted exp %0d got %0d",
               exp.response_accepted, act.response_accepted);
        errors++;
      end
      if (act.noise_count !== exp.noise_count) begin
        $error("noise_count exp %0d got %0d", exp.noise_count, act.noise_count);
        errors++;
      end
      if (act.malformed_count !== exp.malformed_count) begin
        $error("malformed_count exp %0d got %0d", exp.malformed_count, act.malformed_count);
        errors++;
      end
      if (act.unrelated_count !== exp.unrelated_count) begin
        $error("unrelated_count exp %0d got %0d", exp.unrelated_count, act.unrelated_count);
        errors++;
      end
      if (act.accepted_count !== exp.accepted_count) begin
        $error("accepted_count exp %0d got %0d", exp.accepted_count, act.accepted_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  mode = fhp_pkg::MODE_BYTE;
  logic [7:0]  rx_byte = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  handshake_state;
  logic        response_accepted;
  logic [31:0] noise_count, malformed_count, unrelated_count, accepted_count;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = fhp_pkg::REG_SYNC_WORD;
  logic [31:0] cfg_data = 0;

  response_scoreboard sb = new();
  bit          no_idle;
  bit          hold_req;
  int          sent;
  logic [31:0] cur_sync;

  framed_response_handshake_parser i_dut (
    .clk, .rst, .in_valid, .in_stall, .mode, .rx_byte,
    .out_valid, .out_stall, .handshake_state, .response_accepted,
    .noise_count, .malformed_count, .unrelated_count, .accepted_count,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  task automatic send_request(logic [1:0] m, logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    mode <= m;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_request(m, b);
    sent++;
  endtask

  task automatic drain();
    @(posedge clk);
    in_valid <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, data);
    if (idx == fhp_pkg::REG_SYNC_WORD) cur_sync = data;
  endtask

  // frame flavors: 0 good, 1 bad checksum, 2 length too large, 3 truncated
  task automatic send_frame(int flavor, logic [7:0] kind);
    logic [7:0] body[$];
    logic [7:0] sum;
    int len, cut;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, fhp_pkg::DEF_MAX_PAYLOAD)
                                      : $urandom_range(0, 8);
    if (flavor == 2) len = $urandom_range(fhp_pkg::DEF_MAX_PAYLOAD + 1, 16'hFFFF);
    for (int k = 0; k < fhp_pkg::SYNC_LEN; k++) body = {body, cur_sync[8*k +: 8]};
    body = {body, 8'($urandom_range(0, 255))};
    body = {body, kind};
    body = {body, len[7:0]};
    body = {body, len[15:8]};
    if (flavor != 2) begin
      for (int k = 0; k < len; k++) body = {body, 8'($urandom_range(0, 255))};
      sum = 0;
      for (int k = fhp_pkg::POS_SEQ; k < body.size(); k++) sum ^= body[k];
      if (flavor == 1) sum ^= 8'(1 << $urandom_range(0, 7));
      body = {body, sum};
    end
    cut = (flavor == 3) ? $urandom_range(1, body.size() - 1) : body.size();
    for (int k = 0; k < cut; k++) send_request(fhp_pkg::MODE_BYTE, body[k]);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 4);
    // a prefix of the sync word followed by noise exercises the kept tail
    if ($urandom_range(0, 1))
      for (int k = 0; k < $urandom_range(1, 3); k++)
        send_request(fhp_pkg::MODE_BYTE, cur_sync[8*k +: 8]);
    for (int k = 0; k < n; k++) send_request(fhp_pkg::MODE_BYTE, $urandom_range(0, 255));
  endtask

  // hunt in one awaiting phase, reconfiguring between segments, then finish
  task automatic await_phase(bit second, int target);
    logic [7:0] want, other;
    int seg;
    seg = 0;
    while (sent < target) begin
      if (sent >= target - 90 * (5 - seg) && seg < 5) begin
        drain();
        case (seg)
          0: write_reg(fhp_pkg::REG_SYNC_WORD, 32'h0000_0000);
          1: write_reg(fhp_pkg::REG_SYNC_WORD, 32'hFFFF_FFFF);
          default: write_reg(fhp_pkg::REG_SYNC_WORD, $urandom);
        endcase
        write_reg(second ? fhp_pkg::REG_SECOND_TYPE : fhp_pkg::REG_FIRST_TYPE,
                  seg == 0 ? 32'h00 : (seg == 1 ? 32'hFF : $urandom_range(0, 255)));
        no_idle = (seg == 3);
        if (seg == 2 && !second) hold_req = 1;
        seg++;
      end
      want = second ? sb.second_type : sb.first_type;
      other = want ^ 8'($urandom_range(1, 255));
      case ($urandom_range(0, 9))
        0, 1:    send_noise();
        2, 3, 4: send_frame(0, other);
        5, 6:    send_frame(1, $urandom_range(0, 255));
        7:       send_frame(2, $urandom_range(0, 255));
        8:       send_frame(3, $urandom_range(0, 255));
        default: send_request(fhp_pkg::MODE_NONE, $urandom_range(0, 255));
      endcase
    end
    no_idle = 0;
    send_frame(0, second ? sb.second_type : sb.first_type);
  endtask

  // receiver with random stall per result and one long hold
  initial begin
    int w;
    forever begin
      w = $urandom_range(0, 13);
      if (hold_req) begin
        hold_req = 0;
        w = 400;
      end
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(posedge clk);
        out_stall <= 0;
      end
      do @(posedge clk); while (!out_valid);
      sb.check_result({handshake_state, response_accepted, noise_count,
                       malformed_count, unrelated_count, accepted_count});
    end
  end

  initial begin
    #20000000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    int limit;
    sb.clear();
    sent = 0;
    cur_sync = 0;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_reg(fhp_pkg::REG_SYNC_WORD, 32'hA55A_C33C);
    write_reg(fhp_pkg::REG_FIRST_TYPE, 32'h00);
    write_reg(fhp_pkg::REG_SECOND_TYPE, 32'hFF);

    // idle: ignored mode, byte extremes, window overflow without scanning
    send_request(fhp_pkg::MODE_NONE, 8'hFF);
    send_request(fhp_pkg::MODE_BYTE, 8'h00);
    send_request(fhp_pkg::MODE_BYTE, 8'hFF);
    for (int k = 0; k < fhp_pkg::DEF_WINDOW_DEPTH + 2; k++)
      send_request(fhp_pkg::MODE_BYTE, $urandom_range(0, 255));
    send_request(fhp_pkg::MODE_START, 0);
    // unrelated, corrupt, oversized length, truncated
    send_frame(0, 8'h5A);
    send_frame(1, 8'h00);
    send_frame(2, 8'h00);
    send_frame(3, 8'h00);

    await_phase(0, 450);
    for (int k = 0; k < 10; k++) send_request(fhp_pkg::MODE_BYTE, $urandom_range(0, 255));
    send_request(fhp_pkg::MODE_CFG_SENT, 0);
    await_phase(1, 900);

    // done: bytes pile up, then out-of-order events fail the handshake
    for (int k = 0; k < 20; k++) send_request(fhp_pkg::MODE_BYTE, $urandom_range(0, 255));
    drain();
    write_reg(fhp_pkg::REG_FIRST_TYPE, 32'h33);
    send_request(fhp_pkg::MODE_CFG_SENT, 0);
    send_request(fhp_pkg::MODE_START, 0);
    for (int k = 0; k < 20; k++) send_request(fhp_pkg::MODE_BYTE, $urandom_range(0, 255));
    send_request(fhp_pkg::MODE_NONE, 0);

    @(posedge clk);
    in_valid <= 0;
    limit = 0;
    while (sb.expected_results.size() != 0 && limit < 100000) begin
      @(posedge clk);
      limit++;
    end
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/fhp_pkg.sv
rtl/fhp_window_mem.sv
rtl/fhp_scan_ctrl.sv
rtl/framed_response_handshake_parser.sv
verif/testbench.sv
